>>> rtl/core/izhikevich_neuron_update_macros.svh
// assertion helpers for the checker file
`ifndef IZHIKEVICH_NEURON_UPDATE_MACROS_SVH
`define IZHIKEVICH_NEURON_UPDATE_MACROS_SVH

// clocked assertion, quiet while reset is high
`define IZH_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also checks during reset
`define IZH_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/izh_pkg.sv
package izh_pkg;

  localparam int NEURONS  = 1024;
  localparam int SUBSTEPS = 4;

  localparam int ADDR_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int SUB_W  = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;
  localparam logic [16:0] NEURONS_LIM = 17'(NEURONS);

  // floor division by the substep count goes through the shared multiplier:
  // a power of two uses a reciprocal of one and a plain shift, anything else
  // a 31 bit reciprocal and a one-step correction
  localparam bit DIV_POW2 = ((SUBSTEPS & (SUBSTEPS - 1)) == 0);
  localparam int DIV_SHIFT = DIV_POW2 ? $clog2(SUBSTEPS) : 31;
  localparam logic signed [31:0] DIV_RECIP =
    32'(DIV_POW2 ? 64'd1 : (64'd2147483648 / 64'(SUBSTEPS)));
  localparam int Q_SHIFT = 16;

  localparam logic signed [31:0] MAX_S32 = 32'sh7fffffff;
  localparam logic signed [31:0] MIN_S32 = 32'sh80000000;

  typedef enum logic {
    OP_STEP = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_QUAD      = 3'd0,
    REG_LIN       = 3'd1,
    REG_CONST     = 3'd2,
    REG_RATE      = 3'd3,
    REG_SENS      = 3'd4,
    REG_RESET_POT = 3'd5,
    REG_JUMP      = 3'd6,
    REG_THRESH    = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    MODE_Q16,
    MODE_DIV
  } mul_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LATCH,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_SUB,
    ST_M5,
    ST_DIVV,
    ST_DIVU,
    ST_FIX,
    ST_UPD,
    ST_CHK,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [9:0]         neuron;
    logic               disabled;
    logic signed [31:0] input_current;
    logic signed [31:0] init_potential;
    logic signed [31:0] init_recovery;
  } step_t;

  typedef struct packed {
    logic [9:0]         neuron_out;
    logic               updated;
    logic               fired;
    logic signed [31:0] potential;
    logic signed [31:0] recovery;
  } result_t;

  typedef struct packed {
    logic signed [31:0] quad_coeff;
    logic signed [31:0] lin_coeff;
    logic signed [31:0] const_term;
    logic signed [31:0] recovery_rate;
    logic signed [31:0] recovery_sens;
    logic signed [31:0] reset_potential;
    logic signed [31:0] recovery_jump;
    logic signed [31:0] spike_threshold;
  } coef_t;

  localparam coef_t COEF_RESET = '{
    quad_coeff:      32'sd2621,
    lin_coeff:       32'sd327680,
    const_term:      32'sd9175040,
    recovery_rate:   32'sd1311,
    recovery_sens:   32'sd13107,
    reset_potential: -32'sd4259840,
    recovery_jump:   32'sd524288,
    spike_threshold: 32'sd1966080
  };

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] y;
    if (x > 40'(MAX_S32)) begin
      y = MAX_S32;
    end else if (x < 40'(MIN_S32)) begin
      y = MIN_S32;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

  // correct a reciprocal quotient estimate that may be off by one
  function automatic logic signed [31:0] div_fix(input logic signed [31:0] x,
                                                 input logic signed [31:0] q0);
    logic signed [39:0] r;
    logic signed [31:0] q;
    r = 40'(x) - 40'(q0) * 40'(SUBSTEPS);
    if (r < 40'sd0) begin
      q = q0 - 32'sd1;
    end else if (r >= 40'(SUBSTEPS)) begin
      q = q0 + 32'sd1;
    end else begin
      q = q0;
    end
    return q;
  endfunction

endpackage

>>> rtl/core/izhikevich_neuron_update.sv
// channel  dir  handshake              payload
// step     in   step_valid/step_ready  step (izh_pkg::step_t)
// result   out  result_valid/ready     result (izh_pkg::result_t)
// cfg      in   cfg_valid/cfg_ready    cfg_index (3 bit), cfg_data (32 bit)
//
// one request at a time: a load writes the stores, a disabled step reads
// them and reports them unchanged, an index beyond the neuron count goes
// straight to the output, an integrate step runs the substeps and stops early on a spike
// each substep is a chain of seven products on the one shared multiplier
// reset clears the fsm and the result flag and loads the default coefficients;
// stores are not cleared
// a finished result waits in the output register while the next request
// is taken; the sequencer only stalls at its end if that register is full
module izhikevich_neuron_update (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_valid,
  output logic             step_ready,
  input  izh_pkg::step_t   step,
  output logic             result_valid,
  input  logic             result_ready,
  output izh_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  import izh_pkg::*;

  state_t state, state_next;

  // coefficient registers
  coef_t coef;

  // captured request and working state
  step_t              req;
  logic signed [31:0] v, u;
  logic signed [31:0] r1, r2, r3, t;
  logic signed [33:0] acc;
  logic signed [31:0] dv, du, qv0, qu0, qv;
  logic [SUB_W-1:0]   count;
  logic               upd, fired;

  // shared multiplier
  logic signed [31:0] mul_a, mul_b, mul_res;
  mul_mode_t          mul_mode;

  // stores
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [31:0]        pot_rdata, rec_rdata;

  logic step_fire, in_range, spike, out_free, last_sub;

  assign cfg_ready = 1'b1;
  assign step_fire = step_valid && step_ready;
  assign in_range  = 17'(step.neuron) < NEURONS_LIM;
  assign spike     = v >= coef.spike_threshold;
  assign out_free  = !result_valid || result_ready;
  assign last_sub  = count == SUB_W'(SUBSTEPS - 1);
  assign mem_addr  = ADDR_W'(req.neuron);

  izh_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coef     (coef)
  );

  izh_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .mode (mul_mode),
    .res  (mul_res)
  );

  izh_ram #(.WIDTH(32), .DEPTH(NEURONS), .AW(ADDR_W)) u_pot_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (v),
    .raddr (mem_addr),
    .rdata (pot_rdata)
  );

  izh_ram #(.WIDTH(32), .DEPTH(NEURONS), .AW(ADDR_W)) u_rec_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (u),
    .raddr (mem_addr),
    .rdata (rec_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (step_fire) begin
          if (!in_range) begin
            state_next = ST_OUT;
          end else if (step.operation == OP_LOAD) begin
            state_next = ST_WRITE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ:  state_next = ST_LATCH;
      ST_LATCH: state_next = req.disabled ? ST_OUT : ST_M1;
      ST_M1:    state_next = ST_M2;
      ST_M2:    state_next = ST_M3;
      ST_M3:    state_next = ST_M4;
      ST_M4:    state_next = ST_SUB;
      ST_SUB:   state_next = ST_M5;
      ST_M5:    state_next = ST_DIVV;
      ST_DIVV:  state_next = ST_DIVU;
      ST_DIVU:  state_next = ST_FIX;
      ST_FIX:   state_next = ST_UPD;
      ST_UPD:   state_next = ST_CHK;
      ST_CHK:   state_next = (spike || last_sub) ? ST_WRITE : ST_M1;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT:   state_next = out_free ? ST_IDLE : ST_OUT;
      default:  state_next = ST_IDLE;
    endcase
  end

  // fsm outputs: multiplier operands, store write, request ready
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    mul_mode   = MODE_Q16;
    mem_we     = 1'b0;
    step_ready = 1'b0;
    unique case (state)
      ST_IDLE: step_ready = 1'b1;
      ST_M1: begin
        mul_a = coef.quad_coeff;
        mul_b = v;
      end
      ST_M2: begin
        mul_a = coef.lin_coeff;
        mul_b = v;
      end
      ST_M3: begin
        mul_a = r1;
        mul_b = v;
      end
      ST_M4: begin
        mul_a = coef.recovery_sens;
        mul_b = v;
      end
      ST_M5: begin
        mul_a = coef.recovery_rate;
        mul_b = t;
      end
      ST_DIVV: begin
        mul_a    = dv;
        mul_b    = DIV_RECIP;
        mul_mode = MODE_DIV;
      end
      ST_DIVU: begin
        mul_a    = du;
        mul_b    = DIV_RECIP;
        mul_mode = MODE_DIV;
      end
      ST_WRITE: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LATCH) begin
        count <= '0;
      end else if (state == ST_CHK) begin
        count <= count + SUB_W'(1);
      end
    end
  end

  // datapath: each product is read in the state after the one that sets its operands
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (step_fire) begin
          req   <= step;
          upd   <= 1'b0;
          fired <= 1'b0;
          if (!in_range) begin
            v <= '0;
            u <= '0;
          end else begin
            v <= step.init_potential;
            u <= step.init_recovery;
          end
        end
      end
      ST_LATCH: begin
        v   <= pot_rdata;
        u   <= rec_rdata;
        upd <= !req.disabled;
      end
      ST_M2: r1 <= mul_res;
      ST_M3: r2 <= mul_res;
      ST_M4: r3 <= mul_res;
      ST_SUB: begin
        // b*v - u, and the first half of the potential sum
        t   <= sat32(40'(mul_res) - 40'(u));
        acc <= 34'(r3) + 34'(r2) + 34'(coef.const_term);
      end
      ST_M5: dv <= sat32(40'(acc) - 40'(u) + 40'(req.input_current));
      ST_DIVV: du <= mul_res;
      ST_DIVU: qv0 <= mul_res;
      ST_FIX: begin
        qu0 <= mul_res;
        qv  <= div_fix(dv, qv0);
      end
      ST_UPD: begin
        v <= sat32(40'(v) + 40'(qv));
        u <= sat32(40'(u) + 40'(div_fix(du, qu0)));
      end
      ST_CHK: begin
        if (spike) begin
          v     <= coef.reset_potential;
          u     <= sat32(40'(u) + 40'(coef.recovery_jump));
          fired <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      result.neuron_out <= req.neuron;
      result.updated    <= upd;
      result.fired      <= fired;
      result.potential  <= v;
      result.recovery   <= u;
    end
  end

endmodule

>>> rtl/core/izh_ram.sv
module izh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/izh_mul.sv
module izh_mul (
  input  logic                clk,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  input  izh_pkg::mul_mode_t  mode,
  output logic signed [31:0]  res
);

  import izh_pkg::*;

  logic signed [63:0] prod;
  mul_mode_t          prod_mode;
  logic signed [63:0] shifted;
  logic               fits;

  always_ff @(posedge clk) begin
    prod      <= 64'(a) * 64'(b);
    prod_mode <= mode;
  end

  // floor toward minus infinity, then clamp to 32 bit
  always_comb begin
    case (prod_mode)
      MODE_DIV: shifted = prod >>> DIV_SHIFT;
      default:  shifted = prod >>> Q_SHIFT;
    endcase
    fits = (&shifted[63:31]) | ~(|shifted[63:31]);
    if (fits) begin
      res = shifted[31:0];
    end else if (shifted[63]) begin
      res = MIN_S32;
    end else begin
      res = MAX_S32;
    end
  end

endmodule

>>> rtl/core/izh_cfg.sv
module izh_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data,
  output izh_pkg::coef_t     coef
);

  import izh_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= COEF_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_QUAD:      coef.quad_coeff      <= wr_data;
        REG_LIN:       coef.lin_coeff       <= wr_data;
        REG_CONST:     coef.const_term      <= wr_data;
        REG_RATE:      coef.recovery_rate   <= wr_data;
        REG_SENS:      coef.recovery_sens   <= wr_data;
        REG_RESET_POT: coef.reset_potential <= wr_data;
        REG_JUMP:      coef.recovery_jump   <= wr_data;
        REG_THRESH:    coef.spike_threshold <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/izh_checker.sv
`include "izhikevich_neuron_update_macros.svh"

module izh_checker (
  input logic             clk,
  input logic             rst,
  input logic             step_valid,
  input logic             step_ready,
  input logic             result_valid,
  input logic             result_ready,
  input izh_pkg::result_t result
);

  // a stalled result holds
  `IZH_ASSERT(a_result_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result), "result changed while stalled")

  // the block is busy right after taking a request
  `IZH_ASSERT(a_busy_after_take, clk, rst, step_valid && step_ready |=> !step_ready, "ready stayed high after a request")

  // a spike is only reported by an integrate step that ran
  `IZH_ASSERT(a_fired_updated, clk, rst, result_valid |-> !result.fired || result.updated, "fired without update")

  // reset empties the output register
  `IZH_ASSERT_RST(a_reset_empty, clk, rst |=> !result_valid, "result valid after reset")

endmodule

bind izhikevich_neuron_update izh_checker u_izh_checker (.*);
